### hw/rtl/ppq_pkg.sv
// Shared types, constants and command codes of the polygon point query block.
`default_nettype none

package ppq_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned MinVertices = 3;
  localparam int unsigned CoordW      = 24;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned CountW      = 5;
  localparam int unsigned DistW       = 24;
  localparam int unsigned StepW       = 6;
  localparam int unsigned MulSteps    = 10;
  localparam int unsigned CsqSteps    = 3;
  localparam int unsigned DivSteps    = 52;
  localparam int unsigned SqrtSteps   = 26;

  localparam logic [DistW-1:0] DistSat = '1;

  typedef enum logic [3:0] {
    OP_IDLE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_START = 4'd2,
    OP_LDB   = 4'd3,
    OP_LDA   = 4'd4,
    OP_DIFF  = 4'd5,
    OP_MUL   = 4'd6,
    OP_EVAL  = 4'd7,
    OP_CSQ   = 4'd8,
    OP_DIVI  = 4'd9,
    OP_DIV   = 4'd10,
    OP_DMIN  = 4'd11,
    OP_NEXT  = 4'd12,
    OP_SQI   = 4'd13,
    OP_SQ    = 4'd14,
    OP_OUT   = 4'd15
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [StepW-1:0] step;
    logic             short_res;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/ppq_dpath.sv
// Datapath: vertex memory, shared multiplier, divider and square root steps.
`default_nettype none

module ppq_dpath #(
  parameter int unsigned MAX_VERTICES = ppq_pkg::MaxVertices
) (
  input  wire logic                                  clk_i,
  input  wire logic [ppq_pkg::SlotW-1:0]             in_slot_i,
  input  wire logic signed [ppq_pkg::CoordW-1:0]     in_x_i,
  input  wire logic signed [ppq_pkg::CoordW-1:0]     in_y_i,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]       rd_addr_i,
  input  wire ppq_pkg::cmd_t                         cmd_i,
  output ppq_pkg::stat_t                             stat_o,
  output logic                                       inside_o,
  output logic [ppq_pkg::DistW-1:0]                  dist_o
);

  localparam int unsigned IW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = ppq_pkg::CoordW;

  logic [2*CW-1:0] mem_q [MAX_VERTICES];
  logic [2*CW-1:0] rd_q;
  logic [31:0]     slot_ext;
  logic            slot_ok;

  logic signed [CW-1:0] px_q, py_q, ax_q, ay_q, bx_q, by_q;
  logic signed [CW:0]   abx_q, aby_q, apx_q, apy_q, qx_q, qy_q;
  logic signed [53:0]   den_q, dot_q, c_q, e_q, f_q;
  logic [103:0]         sq_q;
  logic [51:0]          rem_q, minq_q, cabs_q, sqop_q;
  logic [27:0]          srem_q;
  logic [25:0]          root_q;
  logic                 inside_q;

  logic signed [26:0] ma, mb;
  logic signed [53:0] prod;
  logic [51:0]        prod_u;
  logic               far_end, near_end, need_div, cross_tog;
  logic [51:0]        cand;
  logic signed [53:0] c_neg;
  logic [52:0]        dt, dt_sub;
  logic               dge;
  logic [29:0]        sr, trial, sr_sub;
  logic               sge;
  logic [ppq_pkg::DistW-1:0] dist_sat;

  assign slot_ext = 32'(in_slot_i);
  assign slot_ok  = slot_ext < MAX_VERTICES;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ppq_pkg::OP_LOAD && slot_ok) begin
      mem_q[slot_ext[IW-1:0]] <= {in_y_i, in_x_i};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // Operand select for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd_i.op == ppq_pkg::OP_CSQ) begin
      unique case (cmd_i.step[1:0])
        2'd0: begin
          ma = $signed({1'b0, cabs_q[25:0]});
          mb = $signed({1'b0, cabs_q[25:0]});
        end
        2'd1: begin
          ma = $signed({1'b0, cabs_q[51:26]});
          mb = $signed({1'b0, cabs_q[25:0]});
        end
        default: begin
          ma = $signed({1'b0, cabs_q[51:26]});
          mb = $signed({1'b0, cabs_q[51:26]});
        end
      endcase
    end else begin
      unique case (cmd_i.step[3:0])
        4'd0:    begin ma = 27'(abx_q); mb = 27'(abx_q); end
        4'd1:    begin ma = 27'(aby_q); mb = 27'(aby_q); end
        4'd2:    begin ma = 27'(apx_q); mb = 27'(abx_q); end
        4'd3:    begin ma = 27'(apy_q); mb = 27'(aby_q); end
        4'd4:    begin ma = 27'(abx_q); mb = 27'(apy_q); end
        4'd5:    begin ma = 27'(aby_q); mb = 27'(apx_q); end
        4'd6:    begin ma = 27'(apx_q); mb = 27'(apx_q); end
        4'd7:    begin ma = 27'(apy_q); mb = 27'(apy_q); end
        4'd8:    begin ma = 27'(qx_q);  mb = 27'(qx_q);  end
        4'd9:    begin ma = 27'(qy_q);  mb = 27'(qy_q);  end
        default: begin ma = '0;         mb = '0;         end
      endcase
    end
  end

  assign prod   = ma * mb;
  assign prod_u = prod[51:0];

  // Edge classification: projection at or beyond the far end, at or before the near end,
  // or strictly inside the segment (then the perpendicular distance needs a divide).
  assign far_end  = (den_q > 54'sd0) && (dot_q >= den_q);
  assign near_end = (den_q == 54'sd0) || (dot_q <= 54'sd0);
  assign need_div = !far_end && !near_end;
  assign cand     = far_end ? f_q[51:0] : e_q[51:0];
  assign c_neg    = -c_q;
  assign cross_tog = ((ay_q > py_q) != (by_q > py_q)) &&
                     ((aby_q > 25'sd0) ? (c_q > 54'sd0) : (c_q < 54'sd0));
  assign stat_o.need_div = need_div;

  assign dt     = {rem_q, sq_q[51]};
  assign dt_sub = dt - den_q[52:0];
  assign dge    = dt >= den_q[52:0];

  assign sr     = {srem_q, sqop_q[51:50]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign sr_sub = sr - trial;
  assign sge    = sr >= trial;

  assign dist_sat = (root_q > 26'(ppq_pkg::DistSat)) ? ppq_pkg::DistSat : root_q[23:0];

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ppq_pkg::OP_START: begin
        px_q     <= in_x_i;
        py_q     <= in_y_i;
        inside_q <= 1'b0;
        minq_q   <= '1;
      end
      ppq_pkg::OP_LDB: begin
        bx_q <= rd_q[CW-1:0];
        by_q <= rd_q[2*CW-1:CW];
      end
      ppq_pkg::OP_LDA: begin
        ax_q <= rd_q[CW-1:0];
        ay_q <= rd_q[2*CW-1:CW];
      end
      ppq_pkg::OP_DIFF: begin
        abx_q <= 25'(bx_q) - 25'(ax_q);
        aby_q <= 25'(by_q) - 25'(ay_q);
        apx_q <= 25'(px_q) - 25'(ax_q);
        apy_q <= 25'(py_q) - 25'(ay_q);
        qx_q  <= 25'(px_q) - 25'(bx_q);
        qy_q  <= 25'(py_q) - 25'(by_q);
      end
      ppq_pkg::OP_MUL: begin
        unique case (cmd_i.step[3:0])
          4'd0:    den_q <= prod;
          4'd1:    den_q <= den_q + prod;
          4'd2:    dot_q <= prod;
          4'd3:    dot_q <= dot_q + prod;
          4'd4:    c_q   <= prod;
          4'd5:    c_q   <= c_q - prod;
          4'd6:    e_q   <= prod;
          4'd7:    e_q   <= e_q + prod;
          4'd8:    f_q   <= prod;
          default: f_q   <= f_q + prod;
        endcase
      end
      ppq_pkg::OP_EVAL: begin
        inside_q <= inside_q ^ cross_tog;
        cabs_q   <= (c_q < 54'sd0) ? c_neg[51:0] : c_q[51:0];
        if (!need_div && cand < minq_q) begin
          minq_q <= cand;
        end
      end
      ppq_pkg::OP_CSQ: begin
        unique case (cmd_i.step[1:0])
          2'd0:    sq_q <= 104'(prod_u);
          2'd1:    sq_q <= sq_q + (104'(prod_u) << 27);
          default: sq_q <= sq_q + {prod_u, 52'd0};
        endcase
      end
      ppq_pkg::OP_DIVI: rem_q <= sq_q[103:52];
      ppq_pkg::OP_DIV: begin
        // Dividend bits shift out of the top, quotient bits shift in below.
        rem_q       <= dge ? dt_sub[51:0] : dt[51:0];
        sq_q[51:0]  <= {sq_q[50:0], dge};
      end
      ppq_pkg::OP_DMIN: begin
        if (sq_q[51:0] < minq_q) begin
          minq_q <= sq_q[51:0];
        end
      end
      ppq_pkg::OP_NEXT: begin
        bx_q <= ax_q;
        by_q <= ay_q;
      end
      ppq_pkg::OP_SQI: begin
        sqop_q <= minq_q;
        srem_q <= '0;
        root_q <= '0;
      end
      ppq_pkg::OP_SQ: begin
        srem_q <= sge ? sr_sub[27:0] : sr[27:0];
        root_q <= {root_q[24:0], sge};
        sqop_q <= {sqop_q[49:0], 2'b00};
      end
      ppq_pkg::OP_OUT: begin
        inside_o <= cmd_i.short_res ? 1'b0 : inside_q;
        dist_o   <= (cmd_i.short_res || inside_q) ? '0 : dist_sat;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/ppq_ctrl.sv
// Controller: query sequencer, vertex count register and result valid flag.
`default_nettype none

module ppq_ctrl #(
  parameter int unsigned MAX_VERTICES = ppq_pkg::MaxVertices
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              in_action_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ppq_pkg::CountW-1:0]        cfg_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [$clog2(MAX_VERTICES)-1:0]        rd_addr_o,
  output ppq_pkg::cmd_t                          cmd_o,
  input  wire ppq_pkg::stat_t                    stat_i
);

  localparam int unsigned IW = $clog2(MAX_VERTICES);
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SW = ppq_pkg::StepW;

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_RDJ  = 16'h0002,
    ST_LDB  = 16'h0004,
    ST_RDA  = 16'h0008,
    ST_LDA  = 16'h0010,
    ST_DIFF = 16'h0020,
    ST_MUL  = 16'h0040,
    ST_EVAL = 16'h0080,
    ST_CSQ  = 16'h0100,
    ST_DIVI = 16'h0200,
    ST_DIV  = 16'h0400,
    ST_DMIN = 16'h0800,
    ST_NEXT = 16'h1000,
    ST_SQI  = 16'h2000,
    ST_SQ   = 16'h4000,
    ST_OUT  = 16'h8000
  } state_e;

  state_e                     state_q, state_d;
  logic [ppq_pkg::CountW-1:0] vcount_q;
  logic [NW-1:0]              n_q, n_d, i_q, i_d, n_now, nm1, i_inc;
  logic [SW-1:0]              step_q, step_d;
  logic                       short_q, short_d;
  logic                       out_valid_q, out_valid_d;
  logic [31:0]                cnt_ext;
  logic                       out_free;

  assign cnt_ext     = 32'(vcount_q);
  assign n_now       = (cnt_ext > MAX_VERTICES) ? NW'(MAX_VERTICES) : cnt_ext[NW-1:0];
  assign nm1         = n_q - NW'(1);
  assign i_inc       = i_q + NW'(1);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign rd_addr_o   = (state_q == ST_RDJ) ? nm1[IW-1:0] : i_q[IW-1:0];

  always_comb begin
    state_d        = state_q;
    n_d            = n_q;
    i_d            = i_q;
    step_d         = step_q;
    short_d        = short_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    in_ready_o     = 1'b0;
    cmd_o.op       = ppq_pkg::OP_IDLE;
    cmd_o.step     = step_q;
    cmd_o.short_res = short_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!in_action_i) begin
            cmd_o.op = ppq_pkg::OP_LOAD;
          end else begin
            cmd_o.op = ppq_pkg::OP_START;
            n_d      = n_now;
            short_d  = n_now < NW'(ppq_pkg::MinVertices);
            state_d  = (n_now < NW'(ppq_pkg::MinVertices)) ? ST_OUT : ST_RDJ;
          end
        end
      end
      ST_RDJ: state_d = ST_LDB;
      ST_LDB: begin
        cmd_o.op = ppq_pkg::OP_LDB;
        i_d      = '0;
        state_d  = ST_RDA;
      end
      ST_RDA: state_d = ST_LDA;
      ST_LDA: begin
        cmd_o.op = ppq_pkg::OP_LDA;
        state_d  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.op = ppq_pkg::OP_DIFF;
        step_d   = '0;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.op = ppq_pkg::OP_MUL;
        step_d   = step_q + SW'(1);
        if (step_q == SW'(ppq_pkg::MulSteps - 1)) begin
          step_d  = '0;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.op = ppq_pkg::OP_EVAL;
        state_d  = stat_i.need_div ? ST_CSQ : ST_NEXT;
      end
      ST_CSQ: begin
        cmd_o.op = ppq_pkg::OP_CSQ;
        step_d   = step_q + SW'(1);
        if (step_q == SW'(ppq_pkg::CsqSteps - 1)) begin
          step_d  = '0;
          state_d = ST_DIVI;
        end
      end
      ST_DIVI: begin
        cmd_o.op = ppq_pkg::OP_DIVI;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = ppq_pkg::OP_DIV;
        step_d   = step_q + SW'(1);
        if (step_q == SW'(ppq_pkg::DivSteps - 1)) begin
          step_d  = '0;
          state_d = ST_DMIN;
        end
      end
      ST_DMIN: begin
        cmd_o.op = ppq_pkg::OP_DMIN;
        state_d  = ST_NEXT;
      end
      ST_NEXT: begin
        cmd_o.op = ppq_pkg::OP_NEXT;
        i_d      = i_inc;
        state_d  = (i_inc == n_q) ? ST_SQI : ST_RDA;
      end
      ST_SQI: begin
        cmd_o.op = ppq_pkg::OP_SQI;
        step_d   = '0;
        state_d  = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.op = ppq_pkg::OP_SQ;
        step_d   = step_q + SW'(1);
        if (step_q == SW'(ppq_pkg::SqrtSteps - 1)) begin
          step_d  = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold the result until the output register is free.
        if (out_free) begin
          cmd_o.op    = ppq_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcount_q    <= '0;
      n_q         <= '0;
      i_q         <= '0;
      step_q      <= '0;
      short_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      i_q         <= i_d;
      step_q      <= step_d;
      short_q     <= short_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        vcount_q <= cfg_data_i;
      end
    end
  end

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not presented after output load");

  a_short_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_action_i &&
     n_now < NW'(ppq_pkg::MinVertices)) |=> (state_q == ST_OUT && short_q))
    else $error("short polygon query did not skip the edge walk");

  a_walk_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDA) |-> (i_q < n_q))
    else $error("edge walk index beyond vertex count");

  a_mul_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (step_q < SW'(ppq_pkg::MulSteps)))
    else $error("multiply step counter out of range");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("input accepted while a query is running");

endmodule

`default_nettype wire

### hw/rtl/polygon_point_query.sv
// Top level of the polygon point query block: controller plus datapath.
`default_nettype none

// Holds a polygon of up to MAX_VERTICES vertices (written by load items) and
// answers query items with the even-odd inside test and, for outside points,
// the floor of the distance to the nearest edge, saturated to 24 bits.
// vertex_count below three answers outside with distance 0. Otherwise each
// edge walks the shared 27x27 multiplier through ten products, and an edge
// whose nearest point lies strictly inside the segment adds a bit-serial
// 52-bit divide; one 26-step bit-serial square root finishes the query. One
// query runs at a time; the next input item is taken while the previous
// result waits on the output.
module polygon_point_query #(
  parameter int unsigned MAX_VERTICES = ppq_pkg::MaxVertices
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [55:0]                  s_axis_tdata,  // vertex_slot, x_pos, y_pos
  input  wire logic                         s_axis_tuser,  // action
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [23:0]                       m_axis_tdata,  // edge_distance
  output logic                              m_axis_tuser,  // inside_res
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ppq_pkg::CountW-1:0]   cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_VERTICES);

  ppq_pkg::cmd_t   cmd;
  ppq_pkg::stat_t  stat;
  logic [IW-1:0]   rd_addr;

  ppq_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .rd_addr_o   (rd_addr),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  ppq_dpath #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dpath (
    .clk_i     (clk_i),
    .in_slot_i (s_axis_tdata[3:0]),
    .in_x_i    ($signed(s_axis_tdata[27:4])),
    .in_y_i    ($signed(s_axis_tdata[51:28])),
    .rd_addr_i (rd_addr),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .inside_o  (m_axis_tuser),
    .dist_o    (m_axis_tdata)
  );

endmodule

`default_nettype wire

### tb/polygon_point_query_test.sv
// Self-checking testbench of the polygon point query block.
`timescale 1ns / 1ps

module polygon_point_query_test;

  localparam int unsigned CycleLimit = 5000000;
  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef struct packed {
    logic                      inside_res;
    logic [ppq_pkg::DistW-1:0] edge_dist;
  } answer_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [55:0]                s_axis_tdata = '0;
  logic                       s_axis_tuser = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [23:0]                m_axis_tdata;
  logic                       m_axis_tuser;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [ppq_pkg::CountW-1:0] cfg_data_i = '0;

  answer_t           answers_due[$];
  int unsigned       fail_count = 0;
  longint unsigned   cycle_count = 0;

  // Shadow polygon and vertex count
  logic signed [ppq_pkg::CoordW-1:0] poly_x [ppq_pkg::MaxVertices];
  logic signed [ppq_pkg::CoordW-1:0] poly_y [ppq_pkg::MaxVertices];
  logic [ppq_pkg::CountW-1:0]        poly_count = '0;

  polygon_point_query dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // vertex_slot, x_pos, y_pos
    .s_axis_tuser  (s_axis_tuser),  // action
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),  // edge_distance
    .m_axis_tuser  (m_axis_tuser),  // inside_res
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("polygon_point_query_test: done, errors");
      $finish;
    end
  end

  // Floor square root of num / den, clamped to 2^24
  function automatic longint unsigned root_floor(logic [127:0] num, logic [127:0] den);
    longint unsigned lo, hi, mid;
    logic [127:0] sq;
    lo = 0;
    hi = 64'd1 << 24;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      sq = 128'(mid) * 128'(mid) * den;
      if (sq <= num) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint unsigned seg_dist(longint px, longint py, longint ax,
                                               longint ay, longint bx, longint by);
    longint abx, aby, apx, apy, den, dot, qx, qy, c;
    abx = bx - ax;
    aby = by - ay;
    apx = px - ax;
    apy = py - ay;
    den = abx * abx + aby * aby;
    dot = apx * abx + apy * aby;
    if (den > 0 && dot >= den) begin
      qx = px - bx;
      qy = py - by;
      return root_floor(128'(qx * qx + qy * qy), 128'd1);
    end
    if (den <= 0 || dot <= 0) return root_floor(128'(apx * apx + apy * apy), 128'd1);
    c = abx * apy - aby * apx;
    if (c < 0) c = -c;
    return root_floor(128'(c) * 128'(c), 128'(den));
  endfunction

  function automatic answer_t point_answer(longint px, longint py);
    answer_t a;
    int unsigned n, j, nx;
    bit in_poly;
    longint xi, yi, xj, yj, d, lhs, rhs;
    longint unsigned best, dd;
    bit left;
    a = '0;
    n = (poly_count > ppq_pkg::MaxVertices) ? ppq_pkg::MaxVertices : poly_count;
    if (n < ppq_pkg::MinVertices) return a;
    in_poly = 0;
    j = n - 1;
    for (int unsigned i = 0; i < n; i++) begin
      xi = poly_x[i]; yi = poly_y[i]; xj = poly_x[j]; yj = poly_y[j];
      if ((yi > py) != (yj > py)) begin
        d = yj - yi;
        lhs = (px - xi) * d;
        rhs = (xj - xi) * (py - yi);
        left = (d > 0) ? (lhs < rhs) : (lhs > rhs);
        if (left) in_poly = !in_poly;
      end
      j = i;
    end
    if (in_poly) begin
      a.inside_res = 1'b1;
      return a;
    end
    best = 64'd1 << 24;
    for (int unsigned i = 0; i < n; i++) begin
      nx = (i + 1) % n;
      dd = seg_dist(px, py, poly_x[i], poly_y[i], poly_x[nx], poly_y[nx]);
      if (dd < best) best = dd;
    end
    a.edge_dist = (best > 64'hFFFFFF) ? ppq_pkg::DistSat : best[ppq_pkg::DistW-1:0];
    return a;
  endfunction

  // Result checker with random stall
  initial begin
    answer_t want;
    int unsigned stall;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (answers_due.size() == 0) begin
          $error("unexpected result: inside_res %0b edge_distance %0d",
                 m_axis_tuser, m_axis_tdata);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (m_axis_tuser !== want.inside_res) begin
            $error("inside_res expected %0b actual %0b", want.inside_res, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata !== want.edge_dist) begin
            $error("edge_distance expected %0d actual %0d", want.edge_dist, m_axis_tdata);
            fail_count++;
          end
        end
        stall = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 9);
        if (stall != 0) m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!m_axis_tready) begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Leave tvalid high after the handshake; a gap before the next item or an idle wait drops it
  task automatic send_item(logic act, logic [ppq_pkg::SlotW-1:0] slot,
                           logic signed [ppq_pkg::CoordW-1:0] x,
                           logic signed [ppq_pkg::CoordW-1:0] y,
                           bit no_gap = 0);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (act == ActQuery) answers_due.insert(answers_due.size(), point_answer(x, y));
    else begin
      poly_x[slot] = x;
      poly_y[slot] = y;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0000, y, x, slot};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_count(logic [ppq_pkg::CountW-1:0] n);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    poly_count = n;
  endtask

  function automatic logic signed [ppq_pkg::CoordW-1:0] rand_coord(int unsigned span);
    case ($urandom_range(0, 5))
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2: return 24'($urandom);
      default: return 24'($signed($urandom_range(0, 2 * span)) - $signed(span));
    endcase
  endfunction

  task automatic test_directed();
    // Too few vertices, then a square, with extremes
    send_item(ActQuery, 0, 0, 0);
    send_item(ActLoad, 0, -1000, -1000);
    send_item(ActLoad, 1, 1000, -1000);
    send_item(ActLoad, 2, 1000, 1000);
    send_item(ActLoad, 3, -1000, 1000);
    set_count(2);
    send_item(ActQuery, 0, 5, 5);
    set_count(4);
    send_item(ActQuery, 15, 0, 0);
    send_item(ActQuery, 0, 3000, 0);
    send_item(ActQuery, 0, 3000, 3000);
    send_item(ActQuery, 0, -1000, 0);
    send_item(ActQuery, 0, 24'sh7FFFFF, 24'sh7FFFFF);
    send_item(ActQuery, 0, 24'sh800000, 24'sh800000);
    send_item(ActQuery, 0, 24'sh800000, 24'sh7FFFFF);
    // Degenerate edge: repeat a vertex
    send_item(ActLoad, 4, -1000, 1000);
    set_count(5);
    send_item(ActQuery, 0, -2000, 1500);
    // Extreme triangle for saturation
    send_item(ActLoad, 0, 24'sh800000, 24'sh800000);
    send_item(ActLoad, 1, 24'sh800001, 24'sh800000);
    send_item(ActLoad, 2, 24'sh800000, 24'sh800001);
    set_count(3);
    send_item(ActQuery, 0, 24'sh7FFFFF, 24'sh7FFFFF);
    send_item(ActQuery, 0, 24'sh800000, 24'sh800000);
  endtask

  task automatic test_random(int unsigned count);
    int unsigned sent, n, span;
    bit big;
    sent = 0;
    while (sent < count) begin
      // An oversized count uses every slot, so load them all first
      big = ($urandom_range(0, 7) == 0);
      n = big ? ppq_pkg::MaxVertices : $urandom_range(3, ppq_pkg::MaxVertices);
      span = ($urandom_range(0, 3) == 0) ? 8388607 : 4000;
      for (int unsigned i = 0; i < n; i++) begin
        send_item(ActLoad, 4'(i), rand_coord(span), rand_coord(span));
        sent++;
      end
      set_count(big ? 5'($urandom_range(17, 31)) : 5'(n));
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(ActLoad, 4'($urandom_range(0, n - 1)), rand_coord(span),
                    rand_coord(span));
        end else begin
          send_item(ActQuery, 4'($urandom), rand_coord(span), rand_coord(span),
                    $urandom_range(0, 3) == 0);
        end
        sent++;
      end
      // Now and then hold off until the queue drains before the next round
      if ($urandom_range(0, 4) == 0) wait_drained();
    end
  endtask

  task automatic test_small_counts();
    set_count(0);
    send_item(ActQuery, 0, 1, 1);
    set_count(1);
    send_item(ActQuery, 0, 24'sh7FFFFF, 24'sh800000);
    for (int unsigned i = 0; i < ppq_pkg::MaxVertices; i++) begin
      send_item(ActLoad, 4'(i), rand_coord(4000), rand_coord(4000));
    end
    set_count(31);
    send_item(ActQuery, 0, 0, 0);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(410);
    test_small_counts();
    wait_drained();
    if (fail_count == 0) $display("polygon_point_query_test: done, clean");
    else $display("polygon_point_query_test: done, errors");
    $finish;
  end

endmodule
